[rtl/core/rgb_to_hsv_converter_defines.svh]
// Assertion macros shared by the RGB to HSV converter RTL.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RHC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RHC_ASSERT_IMP(label, ante, cons, msg) \
  `RHC_ASSERT(label, (ante) |-> (cons), msg)
`else
`define RHC_ASSERT(label, prop, msg)
`define RHC_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

[rtl/core/rhc_pkg.sv]
// Types and constants for the RGB to HSV converter pipeline.
// No dependencies.
package rhc_pkg;

  localparam int unsigned CHAN_W       = 8;
  localparam int unsigned HUE_W        = 15;
  localparam int unsigned SAT_W        = 16;
  // 60 * |diff| is 14 bits; its top 8 bits seed the hue remainder
  localparam int unsigned PROD_W       = 14;
  localparam int unsigned HUE_INT_BITS = 6;

  localparam int unsigned DEG_SECTOR     = 60;
  localparam int unsigned DEG_FULL       = 360;
  localparam int unsigned SECT_OFF_GREEN = 2;
  localparam int unsigned SECT_OFF_BLUE  = 4;

  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } sector_t;

  // Per-pixel control that rides the divider stages
  typedef struct packed {
    logic [CHAN_W-1:0]       mx;
    logic [CHAN_W-1:0]       delta;
    sector_t                 sector;
    logic                    neg;
    logic [HUE_INT_BITS-1:0] alo;   // dividend bits still to shift into hue division
    logic [CHAN_W-1:0]       rsat;  // saturation partial remainder, divisor mx
    logic [CHAN_W-1:0]       rhue;  // hue partial remainder, divisor delta
  } div_ctl_t;

endpackage

[rtl/core/rgb_to_hsv_converter.sv]
// RGB to HSV converter: one 8-bit RGB pixel in, one fixed-point HSV result out.
// Throughput one pixel per cycle when not stalled, set by one restoring-division
// step per pipeline stage for both quotients. Stalls collapse bubbles stage by stage.
// Synchronous active-low reset clears the stage valid bits only.
`include "rgb_to_hsv_converter_defines.svh"
module rgb_to_hsv_converter #(
  parameter int unsigned HUE_FRAC_BITS = 6,
  parameter int unsigned SAT_FRAC_BITS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] out_hue,
  output logic [15:0] out_saturation,
  output logic [7:0]  out_brightness
);
  import rhc_pkg::*;

  localparam int unsigned SQW  = SAT_FRAC_BITS + 1;
  localparam int unsigned HQW  = HUE_INT_BITS + HUE_FRAC_BITS;
  localparam int unsigned NSTG = (SAT_FRAC_BITS > HQW) ? SAT_FRAC_BITS : HQW;

  logic           stg_valid [0:NSTG];
  div_ctl_t       stg_ctl   [0:NSTG];
  logic [SQW-1:0] stg_satq  [0:NSTG];
  logic [HQW-1:0] stg_hueq  [0:NSTG];
  logic           stg_ready [0:NSTG];
  logic           sat_top;

  rhc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .valid_o   (stg_valid[0]),
    .ctl_o     (stg_ctl[0]),
    .sat_top_o (sat_top),
    .ready_i   (stg_ready[0])
  );

  assign stg_satq[0] = SQW'(sat_top);
  assign stg_hueq[0] = '0;

  for (genvar i = 0; i < NSTG; i++) begin : g_div
    rhc_div_stage #(
      .SQW    (SQW),
      .HQW    (HQW),
      .DO_SAT (i < SAT_FRAC_BITS),
      .DO_HUE (i < HQW)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (stg_valid[i]),
      .ctl_i   (stg_ctl[i]),
      .satq_i  (stg_satq[i]),
      .hueq_i  (stg_hueq[i]),
      .ready_o (stg_ready[i]),
      .valid_o (stg_valid[i+1]),
      .ctl_o   (stg_ctl[i+1]),
      .satq_o  (stg_satq[i+1]),
      .hueq_o  (stg_hueq[i+1]),
      .ready_i (stg_ready[i+1])
    );
  end

  rhc_back #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS),
    .SQW           (SQW),
    .HQW           (HQW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid_i        (stg_valid[NSTG]),
    .ctl_i          (stg_ctl[NSTG]),
    .satq_i         (stg_satq[NSTG]),
    .hueq_i         (stg_hueq[NSTG]),
    .ready_o        (stg_ready[NSTG]),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness)
  );

  `RHC_ASSERT(free_output_frees_input, !out_stall |-> !in_stall, "input stalled while output is free")
  `RHC_ASSERT_IMP(black_is_gray, out_valid && out_brightness == 8'd0, out_saturation == 16'd0 && out_hue == 15'd0, "black pixel with nonzero hue or saturation")
  `RHC_ASSERT_IMP(hue_needs_sat, out_valid && out_hue != 15'd0, out_saturation != 16'd0 || SAT_FRAC_BITS > 15, "nonzero hue with zero saturation")

endmodule

[rtl/core/rhc_front.sv]
// Front end: max/min/sector pick, then delta, |diff| * 60 and divider seeds.
// Two register stages; uses rhc_pkg.
module rhc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_red,
  input  logic [7:0]                    in_green,
  input  logic [7:0]                    in_blue,
  output logic                          valid_o,
  output rhc_pkg::div_ctl_t             ctl_o,
  output logic                          sat_top_o,
  input  logic                          ready_i
);
  import rhc_pkg::*;

  logic              a_valid_r;
  logic [CHAN_W-1:0] a_mx_r, a_mn_r, a_p_r, a_q_r;
  sector_t           a_sect_r;
  logic              b_valid_r;
  div_ctl_t          b_ctl_r;
  logic              b_top_r;

  logic              ready_a, ready_b;
  logic [CHAN_W-1:0] mx_nxt, mn_nxt, p_nxt, q_nxt;
  sector_t           sect_nxt;

  logic [CHAN_W-1:0] delta;
  logic [CHAN_W:0]   diff;
  logic [CHAN_W-1:0] mag;
  logic [PROD_W-1:0] prod;
  logic              top;
  div_ctl_t          ctl_nxt;

  assign ready_b  = !b_valid_r || ready_i;
  assign ready_a  = !a_valid_r || ready_b;
  assign in_stall = !ready_a;

  // red wins ties, then green
  always_comb begin
    if (in_red >= in_green && in_red >= in_blue) begin
      sect_nxt = SECT_RED;
      mx_nxt   = in_red;
    end else if (in_green >= in_blue) begin
      sect_nxt = SECT_GREEN;
      mx_nxt   = in_green;
    end else begin
      sect_nxt = SECT_BLUE;
      mx_nxt   = in_blue;
    end
    mn_nxt = in_red;
    if (in_green < mn_nxt) mn_nxt = in_green;
    if (in_blue < mn_nxt) mn_nxt = in_blue;
    case (sect_nxt)
      SECT_RED: begin
        p_nxt = in_green;
        q_nxt = in_blue;
      end
      SECT_GREEN: begin
        p_nxt = in_blue;
        q_nxt = in_red;
      end
      SECT_BLUE: begin
        p_nxt = in_red;
        q_nxt = in_green;
      end
      default: begin
        p_nxt = in_red;
        q_nxt = in_green;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (ready_a) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && in_valid) begin
      a_mx_r   <= mx_nxt;
      a_mn_r   <= mn_nxt;
      a_p_r    <= p_nxt;
      a_q_r    <= q_nxt;
      a_sect_r <= sect_nxt;
    end
  end

  always_comb begin
    delta = a_mx_r - a_mn_r;
    diff  = {1'b0, a_p_r} - {1'b0, a_q_r};
    mag   = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
    // x * 60 = x * 64 - x * 4
    prod  = (PROD_W'(mag) << 6) - (PROD_W'(mag) << 2);
    // delta == mx only when min is zero: quotient is exactly one
    top   = (delta == a_mx_r);
    ctl_nxt.mx     = a_mx_r;
    ctl_nxt.delta  = delta;
    ctl_nxt.sector = a_sect_r;
    ctl_nxt.neg    = diff[CHAN_W];
    ctl_nxt.alo    = prod[HUE_INT_BITS-1:0];
    ctl_nxt.rsat   = top ? '0 : delta;
    ctl_nxt.rhue   = prod[PROD_W-1:HUE_INT_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (ready_b) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b && a_valid_r) begin
      b_ctl_r <= ctl_nxt;
      b_top_r <= top;
    end
  end

  assign valid_o   = b_valid_r;
  assign ctl_o     = b_ctl_r;
  assign sat_top_o = b_top_r;

endmodule

[rtl/core/rhc_div_stage.sv]
// One registered restoring-division step for saturation, hue or both (DO_SAT, DO_HUE).
// Uses rhc_pkg and the assertion macros header.
`include "rgb_to_hsv_converter_defines.svh"
module rhc_div_stage #(
  parameter int unsigned SQW    = 16,
  parameter int unsigned HQW    = 12,
  parameter bit          DO_SAT = 1'b1,
  parameter bit          DO_HUE = 1'b1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   valid_i,
  input  rhc_pkg::div_ctl_t      ctl_i,
  input  logic [SQW-1:0]         satq_i,
  input  logic [HQW-1:0]         hueq_i,
  output logic                   ready_o,
  output logic                   valid_o,
  output rhc_pkg::div_ctl_t      ctl_o,
  output logic [SQW-1:0]         satq_o,
  output logic [HQW-1:0]         hueq_o,
  input  logic                   ready_i
);
  import rhc_pkg::*;

  logic           valid_r;
  div_ctl_t       ctl_r, ctl_nxt;
  logic [SQW-1:0] satq_r, satq_nxt;
  logic [HQW-1:0] hueq_r, hueq_nxt;
  logic [CHAN_W:0] s_step, h_step;

  // remainder stays below the divisor, so the shifted value fits 9 bits
  function automatic logic [CHAN_W:0] div_step(input logic [CHAN_W-1:0] rem,
                                               input logic [CHAN_W-1:0] den,
                                               input logic              bin);
    logic [CHAN_W:0] t;
    logic [CHAN_W:0] d;
    t = {rem, bin};
    d = {1'b0, den};
    if (t >= d) begin
      div_step = {1'b1, CHAN_W'(t - d)};
    end else begin
      div_step = {1'b0, t[CHAN_W-1:0]};
    end
  endfunction

  assign ready_o = !valid_r || ready_i;

  always_comb begin
    ctl_nxt  = ctl_i;
    satq_nxt = satq_i;
    hueq_nxt = hueq_i;
    s_step   = div_step(ctl_i.rsat, ctl_i.mx, 1'b0);
    h_step   = div_step(ctl_i.rhue, ctl_i.delta, ctl_i.alo[HUE_INT_BITS-1]);
    if (DO_SAT) begin
      ctl_nxt.rsat = s_step[CHAN_W-1:0];
      satq_nxt     = {satq_i[SQW-2:0], s_step[CHAN_W]};
    end
    if (DO_HUE) begin
      ctl_nxt.rhue = h_step[CHAN_W-1:0];
      ctl_nxt.alo  = {ctl_i.alo[HUE_INT_BITS-2:0], 1'b0};
      hueq_nxt     = {hueq_i[HQW-2:0], h_step[CHAN_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      ctl_r  <= ctl_nxt;
      satq_r <= satq_nxt;
      hueq_r <= hueq_nxt;
    end
  end

  assign valid_o = valid_r;
  assign ctl_o   = ctl_r;
  assign satq_o  = satq_r;
  assign hueq_o  = hueq_r;

  `RHC_ASSERT_IMP(rem_below_divisor, valid_r && ctl_r.delta != 8'd0, ctl_r.rhue < ctl_r.delta && ctl_r.rsat < ctl_r.mx, "partial remainder not below divisor")

endmodule

[rtl/core/rhc_back.sv]
// Back end: hue sign fix, sector offset and wrap, gray zeroing; output register.
// Uses rhc_pkg.
module rhc_back #(
  parameter int unsigned HUE_FRAC_BITS = 6,
  parameter int unsigned SQW           = 16,
  parameter int unsigned HQW           = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   valid_i,
  input  rhc_pkg::div_ctl_t      ctl_i,
  input  logic [SQW-1:0]         satq_i,
  input  logic [HQW-1:0]         hueq_i,
  output logic                   ready_o,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [14:0]            out_hue,
  output logic [15:0]            out_saturation,
  output logic [7:0]             out_brightness
);
  import rhc_pkg::*;

  // signed width that holds +/- 360 degrees in hue units
  localparam int unsigned HSW       = 10 + HUE_FRAC_BITS;
  localparam int unsigned OFF_GREEN = (SECT_OFF_GREEN * DEG_SECTOR) << HUE_FRAC_BITS;
  localparam int unsigned OFF_BLUE  = (SECT_OFF_BLUE * DEG_SECTOR) << HUE_FRAC_BITS;
  localparam int unsigned FULL_TURN = DEG_FULL << HUE_FRAC_BITS;

  logic              out_valid_r;
  logic [HUE_W-1:0]  hue_r, hue_nxt;
  logic [SAT_W-1:0]  sat_r, sat_nxt;
  logic [CHAN_W-1:0] val_r;

  logic signed [HSW-1:0] q_s, frac_s, off_s, sum_s, wrap_s, hue_s;
  logic [HSW-1:0]        round_up;
  logic [31:0]           hue32, sat32;

  assign ready_o = !out_valid_r || !out_stall;

  always_comb begin
    q_s      = signed'(HSW'(hueq_i));
    round_up = HSW'(ctl_i.rhue != 8'd0);
    // floor of a negative quotient: negate and round the magnitude up
    frac_s   = ctl_i.neg ? -(q_s + signed'(round_up)) : q_s;
    case (ctl_i.sector)
      SECT_RED:   off_s = '0;
      SECT_GREEN: off_s = signed'(HSW'(OFF_GREEN));
      SECT_BLUE:  off_s = signed'(HSW'(OFF_BLUE));
      default:    off_s = '0;
    endcase
    sum_s  = off_s + frac_s;
    wrap_s = sum_s + signed'(HSW'(FULL_TURN));
    hue_s  = sum_s[HSW-1] ? wrap_s : sum_s;
    hue32  = 32'(hue_s);
    sat32  = 32'(satq_i);
    if (ctl_i.delta == 8'd0) begin
      hue_nxt = '0;
      sat_nxt = '0;
    end else begin
      hue_nxt = hue32[HUE_W-1:0];
      sat_nxt = sat32[SAT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ready_o) begin
      out_valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      val_r <= ctl_i.mx;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = val_r;

endmodule
